// ----- src/rfd_pkg.sv -----
// Shared types and constants for the reply frame deframer.
`timescale 1ns / 1ps

package rfd_pkg;

    localparam logic [7:0]  HDR_START  = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'hBB;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [15:0] byte_index;
        logic        in_checksum;
        logic        frame_done;
        logic [15:0] frame_length;
    } t_result;

endpackage

// ----- src/rfd_if.sv -----
// Valid/ready channel interfaces for received bytes and deframer results.
`timescale 1ns / 1ps

interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       line_error;

    modport source (output valid, output rx_byte, output line_error, input ready);
    modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

interface rfd_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [15:0] byte_index;
    logic        in_checksum;
    logic        frame_done;
    logic [15:0] frame_length;

    modport source (output valid, output accepted, output byte_index, output in_checksum,
                    output frame_done, output frame_length, input ready);
    modport sink   (input valid, input accepted, input byte_index, input in_checksum,
                    input frame_done, input frame_length, output ready);
endinterface

// ----- src/rfd_engine.sv -----
// Frame state registers and the per-byte deframing logic.
`timescale 1ns / 1ps

module rfd_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  rfd_pkg::t_in_item i_item,
    output rfd_pkg::t_result  o_result
);

    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_GOT_START = 3'd1;
    localparam logic [2:0] MODE_LEN_LO    = 3'd2;
    localparam logic [2:0] MODE_LEN_HI    = 3'd3;
    localparam logic [2:0] MODE_BODY      = 3'd4;

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_len,  n_len;
    logic [7:0]  r_xor,  n_xor;
    logic [15:0] r_pos,  n_pos;

    logic [16:0] len_p2;
    logic [16:0] len_p3;
    logic [15:0] idx;
    logic        folded;
    logic        done;

    assign len_p2 = {1'b0, r_len} + 17'd2;
    assign len_p3 = {1'b0, r_len} + 17'd3;

    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        n_xor  = r_xor;
        n_pos  = r_pos;
        idx    = r_pos;
        folded = 1'b0;
        done   = 1'b0;
        if (!i_item.line_error) begin
            if (i_item.rx_byte == rfd_pkg::HDR_START) begin
                n_xor  = 8'h00;
                n_mode = MODE_GOT_START;
                idx    = 16'd0;
            end else if (r_mode == MODE_GOT_START && i_item.rx_byte == rfd_pkg::HDR_SECOND) begin
                n_len  = 16'd0;
                n_mode = MODE_LEN_LO;
            end else if (r_mode == MODE_LEN_LO) begin
                n_len  = {r_len[15:8], i_item.rx_byte};
                n_mode = MODE_LEN_HI;
            end else if (r_mode == MODE_LEN_HI) begin
                n_len  = {i_item.rx_byte, r_len[7:0]};
                n_mode = MODE_BODY;
            end else if (r_mode == MODE_BODY) begin
                if (r_pos >= 16'd2 && {1'b0, r_pos} <= len_p2) begin
                    n_xor  = r_xor ^ i_item.rx_byte;
                    folded = 1'b1;
                end else if ({1'b0, r_pos} == len_p3 && i_item.rx_byte == r_xor) begin
                    done = 1'b1;
                end
            end
            // position saturates at the top instead of wrapping
            n_pos = (idx < rfd_pkg::POS_MAX) ? idx + 16'd1 : idx;
        end
    end

    always_comb begin
        o_result.accepted     = !i_item.line_error;
        o_result.byte_index   = i_item.line_error ? 16'd0 : idx;
        o_result.in_checksum  = folded;
        o_result.frame_done   = done;
        o_result.frame_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_len  <= 16'd0;
            r_xor  <= 8'h00;
            r_pos  <= 16'd0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_xor  <= n_xor;
            r_pos  <= n_pos;
        end
    end

    a_fold_excl_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(folded && done))
        else $error("byte both folded and flagged as check byte");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_item.line_error && i_item.rx_byte == rfd_pkg::HDR_START)
        |=> (r_pos == 16'd1 && r_xor == 8'h00 && r_mode == MODE_GOT_START))
        else $error("start byte did not restart the frame");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.line_error)
        |=> ($stable(r_mode) && $stable(r_len) && $stable(r_xor) && $stable(r_pos)))
        else $error("errored byte changed frame state");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_item.line_error && i_item.rx_byte != rfd_pkg::HDR_START
         && r_pos != rfd_pkg::POS_MAX)
        |=> (r_pos == $past(r_pos) + 16'd1))
        else $error("position did not advance by one");

endmodule

// ----- src/reply_frame_deframer.sv -----
// Top level of the reply frame deframer: input register, engine, result register.
//
//  channel  | dir | payload                                               | handshake
//  i_in     | in  | rx_byte[7:0], line_error                             | valid/ready
//  o_out    | out | accepted, byte_index[15:0], in_checksum, frame_done,  | valid/ready
//           |     | frame_length[15:0]                                    |
//
// One byte per cycle sustained while o_out.ready stays high; a taken request moves from the
// input register through the engine into the result register, which drives o_out. The input
// register feeds the engine, which updates frame state and loads the result register in the
// same cycle. Stalls on o_out back up through the input register, so i_in.ready drops only
// when both registers hold requests and o_out.ready is low. Reset is synchronous and clears
// frame state and both valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module reply_frame_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rfd_in_if.sink        i_in,
    rfd_out_if.source     o_out
);

    logic              r_s1_valid;
    rfd_pkg::t_in_item r_s1_item;
    logic              r_out_valid;
    rfd_pkg::t_result  r_out_res;

    rfd_pkg::t_result  eng_res;
    logic              out_free;
    logic              advance;
    logic              in_take;

    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || advance;
    assign in_take  = i_in.valid && i_in.ready;

    rfd_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_s1_item),
        .o_result  (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.rx_byte    <= i_in.rx_byte;
            r_s1_item.line_error <= i_in.line_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= eng_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.accepted     = r_out_res.accepted;
    assign o_out.byte_index   = r_out_res.byte_index;
    assign o_out.in_checksum  = r_out_res.in_checksum;
    assign o_out.frame_done   = r_out_res.frame_done;
    assign o_out.frame_length = r_out_res.frame_length;

endmodule

// ----- tb/sv/reply_frame_deframer_test.sv -----
// Self-checking testbench for the reply frame deframer: directed and random runs.
`timescale 1ns / 1ps

module reply_frame_deframer_test;

    localparam int ITEM_TARGET  = 1150;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 6;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_GOT_START,
        MODE_LEN_LO,
        MODE_LEN_HI,
        MODE_BODY
    } t_frame_mode;

    // Tracks the frame state and holds the results the deframer owes us.
    class frame_tracker;
        t_frame_mode      mode;
        logic [15:0]      length_f;
        logic [15:0]      position;
        logic [7:0]       xor_acc;
        rfd_pkg::t_result pending_results[$];
        int               errors;

        function new();
            mode     = MODE_IDLE;
            length_f = '0;
            position = '0;
            xor_acc  = '0;
            errors   = 0;
        endfunction

        function rfd_pkg::t_result predict_byte(logic [7:0] b, logic err);
            rfd_pkg::t_result r;
            int unsigned      pos_i;
            int unsigned      len_i;
            r = '0;
            if (err) begin
                r.frame_length = length_f;
                return r;
            end
            if (b == rfd_pkg::HDR_START) begin
                position = '0;
                xor_acc  = '0;
                mode     = MODE_GOT_START;
            end else if (mode == MODE_GOT_START && b == rfd_pkg::HDR_SECOND) begin
                length_f = '0;
                mode     = MODE_LEN_LO;
            end else if (mode == MODE_LEN_LO) begin
                length_f[7:0] = b;
                mode          = MODE_LEN_HI;
            end else if (mode == MODE_LEN_HI) begin
                length_f[15:8] = b;
                mode           = MODE_BODY;
            end else if (mode == MODE_BODY) begin
                // 32-bit bounds so a length near the top never wraps
                pos_i = position;
                len_i = length_f;
                if (pos_i >= 2 && pos_i - 2 <= len_i) begin
                    xor_acc       = xor_acc ^ b;
                    r.in_checksum = 1'b1;
                end else if (pos_i == len_i + 3 && b == xor_acc) begin
                    r.frame_done = 1'b1;
                end
            end
            r.accepted   = 1'b1;
            r.byte_index = position;
            if (position != rfd_pkg::POS_MAX)
                position = position + 16'd1;
            r.frame_length = length_f;
            return r;
        endfunction

        function void take_byte(logic [7:0] b, logic err);
            pending_results.push_back(predict_byte(b, err));
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned got);
            if (exp != got) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp, got);
                errors++;
            end
        endfunction

        function void check_result(rfd_pkg::t_result got);
            rfd_pkg::t_result exp;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual accepted=%0d index=0x%0h",
                         $time, got.accepted, got.byte_index);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            compare_field("accepted", exp.accepted, got.accepted);
            compare_field("byte_index", exp.byte_index, got.byte_index);
            compare_field("in_checksum", exp.in_checksum, got.in_checksum);
            compare_field("frame_done", exp.frame_done, got.frame_done);
            compare_field("frame_length", exp.frame_length, got.frame_length);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rfd_in_if  in_ch ();
    rfd_out_if out_ch ();

    reply_frame_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    frame_tracker tracker = new();

    bit calm;
    bit hold_req;
    int data_items;
    int stall_cycles;

    // err flag in bit 8, byte below
    logic [8:0] directed_seq [28] = '{
        9'h1FF, 9'h0BB, 9'h0AA, 9'h055, 9'h0BB, 9'h003, 9'h000, 9'h07E,
        9'h1AA, 9'h07E, 9'h07E, 9'h0AA, 9'h0BB, 9'h0FF, 9'h0FF, 9'h001,
        9'h0FF, 9'h0AA, 9'h0BB, 9'h000, 9'h000, 9'h000, 9'h0AA, 9'h0BB,
        9'h002, 9'h000, 9'h0C3, 9'h0C2
    };

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sender: one request per call, held until the deframer takes it.
    task automatic send_byte(input logic [7:0] b, input logic err);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 35) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.rx_byte    = b;
        in_ch.line_error = err;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.take_byte(b, err);
        if (!err)
            data_items++;
    endtask

    // Clean byte, sometimes preceded by a corrupted one.
    task automatic put(input logic [7:0] b);
        if ($urandom_range(99) < 4)
            send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(b, 1'b0);
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == rfd_pkg::HDR_START)
            b = 8'h00;
        return b;
    endfunction

    // Drops valid and waits for every owed result.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [15:0] len, input int unsigned body_max,
                              input bit good_check);
        int unsigned n;
        bit          cut;
        logic [7:0]  x;
        logic [7:0]  b;
        logic [7:0]  d;
        n   = (len >= 1) ? len - 1 : 0;
        cut = n > body_max;
        if (cut)
            n = body_max;
        put(rfd_pkg::HDR_START);
        if ($urandom_range(99) < 10) begin
            b = body_byte();
            put(b == rfd_pkg::HDR_SECOND ? 8'h5A : b);
        end
        put(rfd_pkg::HDR_SECOND);
        put(len[7:0]);
        put(len[15:8]);
        x = '0;
        for (int unsigned i = 0; i < n; i++) begin
            b = body_byte();
            // keep the check byte from reading as a frame start
            if (i == n - 1 && (x ^ b) == rfd_pkg::HDR_START) begin
                d = ((b ^ 8'h01) == rfd_pkg::HDR_START) ? 8'h02 : 8'h01;
                b = b ^ d;
            end
            x = x ^ b;
            put(b);
        end
        if (!cut)
            put(good_check ? x : x ^ 8'($urandom_range(1, 255)));
    endtask

    // Result side: ready pattern with one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req     = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = calm || ($urandom_range(99) >= 35);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_result('{out_ch.accepted, out_ch.byte_index, out_ch.in_checksum,
                                   out_ch.frame_done, out_ch.frame_length});
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("reply_frame_deframer test failed");
                $finish;
            end
        end
    end

    initial begin
        bit          held_early;
        bit          held_late;
        bit          paused;
        logic [15:0] len;

        in_ch.valid      = 1'b0;
        in_ch.rx_byte    = '0;
        in_ch.line_error = 1'b0;
        i_rst_n          = 1'b0;
        calm             = 1'b0;
        hold_req         = 1'b0;
        data_items       = 0;
        stall_cycles     = 0;
        held_early       = 1'b0;
        held_late        = 1'b0;
        paused           = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_seq[i])
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        drain();

        while (data_items < ITEM_TARGET) begin
            if (!held_early && data_items > 300) begin
                held_early = 1'b1;
                hold_req   = 1'b1;
            end
            if (!held_late && data_items > 900) begin
                held_late = 1'b1;
                hold_req  = 1'b1;
            end
            if (!paused && data_items > 700) begin
                paused = 1'b1;
                drain();
            end
            calm = data_items > 420 && data_items < 580;
            case ($urandom_range(9))
                0: repeat ($urandom_range(1, 4)) put(8'($urandom_range(255)));
                1: begin
                    case ($urandom_range(3))
                        0: len = 16'hFFFF;
                        1: len = 16'hFFFE;
                        2: len = 16'hFFFD;
                        default: len = 16'($urandom_range(16'hFFFF));
                    endcase
                    send_frame(len, $urandom_range(20), 1'b1);
                end
                default: begin
                    send_frame(16'($urandom_range(14)), 100, $urandom_range(99) < 80);
                    repeat ($urandom_range(2)) put(body_byte());
                end
            endcase
        end
        calm = 1'b0;
        drain();

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("reply_frame_deframer test passed");
        end else begin
            $display("reply_frame_deframer test failed");
        end
        $finish;
    end

endmodule
